>>> design/jhds_pkg.sv
package jhds_pkg;

    localparam int unsigned HDR_BYTES = 9;
    localparam logic [3:0] MIN_FILE = 4'd10;

    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] MARK_SOI = 8'hD8;
    localparam logic [7:0] MARK_SOF0 = 8'hC0;
    localparam logic [7:0] MARK_SOF2 = 8'hC2;
    localparam logic [7:0] MARK_SOS = 8'hDA;

    localparam logic [2:0] ST_FOUND = 3'd0;
    localparam logic [2:0] ST_SHORT = 3'd1;
    localparam logic [2:0] ST_NOTJPEG = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_LOST = 3'd4;
    localparam logic [2:0] ST_END = 3'd5;

    typedef logic [HDR_BYTES-1:0][7:0] hdr_win_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } byte_item_t;

    typedef struct packed {
        logic [2:0]  scan_status;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } result_item_t;

    typedef struct packed {
        logic        lost;
        logic        found;
        logic        scan;
        logic [15:0] height;
        logic [15:0] width;
        logic        to_skip;
        logic [16:0] skip_count;
        logic [3:0]  next_offset;
        hdr_win_t    next_win;
    } hdr_res_t;

endpackage

>>> design/jpeg_header_dimension_scan_core.sv
// Scans a JPEG file presented one byte per transaction and reports the image
// dimensions from the first SOF0 or SOF2 header, or a status saying why none
// was found. One byte is taken every cycle unless a final byte is held back as
// below; each file's single result is registered into the output buffer. Results are
// buffered two deep, so a final byte waits only while two earlier results are
// still held. After a result the block is ready for the next file at once.
module jpeg_header_dimension_scan_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_ready,
    input  jhds_pkg::byte_item_t   byte_item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output jhds_pkg::result_item_t result_item
);
    import jhds_pkg::*;

    localparam logic [1:0] PH_SOI0 = 2'd0;
    localparam logic [1:0] PH_SOI1 = 2'd1;
    localparam logic [1:0] PH_WIN = 2'd2;
    localparam logic [1:0] PH_SKIP = 2'd3;

    logic [1:0]   phase_reg, phase_next;
    logic [3:0]   offset_reg, offset_next;
    logic [16:0]  skip_reg, skip_next;
    logic [15:0]  height_reg, height_next;
    logic [15:0]  width_reg, width_next;
    logic [2:0]   pending_reg, pending_next;
    logic [3:0]   count_reg, count_next;
    logic         decided_reg, decided_next;
    hdr_win_t     win_reg, win_next;
    hdr_win_t     win_fill;
    logic [3:0]   offset_fill;
    logic [16:0]  skip_dec;
    hdr_res_t     hdr;
    logic         accept;
    logic         push;
    logic         pop;
    logic [2:0]   status;
    result_item_t result_next;
    logic         result_valid_reg;
    result_item_t result_reg;
    logic         spare_valid_reg;
    result_item_t spare_reg;

    assign byte_ready = !(byte_item.final_byte && spare_valid_reg);
    assign accept = byte_valid && byte_ready;
    assign push = accept && byte_item.final_byte;
    assign pop = result_valid_reg && result_ready;

    always_comb
    begin
        win_fill = win_reg;
        if (offset_reg < 4'(HDR_BYTES))
        begin
            win_fill[offset_reg] = byte_item.data_byte;
        end
        offset_fill = offset_reg + 4'd1;
    end

    jhds_header u_header (
        .win (win_fill),
        .res (hdr)
    );

    assign skip_dec = (skip_reg != 17'd0) ? skip_reg - 17'd1 : skip_reg;

    always_comb
    begin
        phase_next = phase_reg;
        offset_next = offset_reg;
        skip_next = skip_reg;
        height_next = height_reg;
        width_next = width_reg;
        pending_next = pending_reg;
        count_next = count_reg;
        decided_next = decided_reg;
        win_next = win_reg;
        result_next = '0;

        if (count_reg < MIN_FILE)
        begin
            count_next = count_reg + 4'd1;
        end

        if (!decided_reg)
        begin
            case (phase_reg)
                PH_SOI0:
                begin
                    if (byte_item.data_byte != MARK_PREFIX)
                    begin
                        decided_next = 1'b1;
                        pending_next = ST_NOTJPEG;
                    end
                    else
                    begin
                        phase_next = PH_SOI1;
                    end
                end
                PH_SOI1:
                begin
                    if (byte_item.data_byte != MARK_SOI)
                    begin
                        decided_next = 1'b1;
                        pending_next = ST_NOTJPEG;
                    end
                    else
                    begin
                        phase_next = PH_WIN;
                        offset_next = 4'd0;
                    end
                end
                PH_WIN:
                begin
                    win_next = win_fill;
                    offset_next = offset_fill;
                    if (offset_fill >= 4'(HDR_BYTES))
                    begin
                        if (hdr.lost)
                        begin
                            decided_next = 1'b1;
                            pending_next = ST_LOST;
                        end
                        else if (hdr.found)
                        begin
                            decided_next = 1'b1;
                            pending_next = ST_FOUND;
                            height_next = hdr.height;
                            width_next = hdr.width;
                        end
                        else if (hdr.scan)
                        begin
                            decided_next = 1'b1;
                            pending_next = ST_SCAN;
                        end
                        else
                        begin
                            skip_next = hdr.skip_count;
                            offset_next = hdr.next_offset;
                            win_next = hdr.next_win;
                            phase_next = hdr.to_skip ? PH_SKIP : PH_WIN;
                        end
                    end
                end
                default:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 17'd0)
                    begin
                        phase_next = PH_WIN;
                        offset_next = 4'd0;
                    end
                end
            endcase
        end

        status = (count_next < MIN_FILE) ? ST_SHORT : pending_next;
        result_next.scan_status = status;
        result_next.image_width = (status == ST_FOUND) ? width_next : 16'd0;
        result_next.image_height = (status == ST_FOUND) ? height_next : 16'd0;

        if (byte_item.final_byte)
        begin
            phase_next = PH_SOI0;
            offset_next = 4'd0;
            skip_next = 17'd0;
            height_next = 16'd0;
            width_next = 16'd0;
            pending_next = ST_END;
            count_next = 4'd0;
            decided_next = 1'b0;
            win_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SOI0;
            offset_reg <= 4'd0;
            skip_reg <= 17'd0;
            height_reg <= 16'd0;
            width_reg <= 16'd0;
            pending_reg <= ST_END;
            count_reg <= 4'd0;
            decided_reg <= 1'b0;
            win_reg <= '0;
            result_valid_reg <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                offset_reg <= offset_next;
                skip_reg <= skip_next;
                height_reg <= height_next;
                width_reg <= width_next;
                pending_reg <= pending_next;
                count_reg <= count_next;
                decided_reg <= decided_next;
                win_reg <= win_next;
            end
            if (spare_valid_reg)
            begin
                if (pop)
                begin
                    spare_valid_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                result_valid_reg <= 1'b1;
                spare_valid_reg <= result_valid_reg && !pop;
            end
            else if (pop)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (spare_valid_reg)
        begin
            if (pop)
            begin
                result_reg <= spare_reg;
            end
        end
        else if (push)
        begin
            if (result_valid_reg && !pop)
            begin
                spare_reg <= result_next;
            end
            else
            begin
                result_reg <= result_next;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item = result_reg;

    a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && byte_item.final_byte) |=> result_valid)
        else $error("final byte did not produce a result");

    a_dims_only_when_found: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_item.scan_status != ST_FOUND) |->
        (result_item.image_width == 16'd0 && result_item.image_height == 16'd0))
        else $error("dimensions reported without a found status");

    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP && !decided_reg) |-> (skip_reg != 17'd0))
        else $error("skip phase entered with nothing to skip");

    a_offset_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WIN && !decided_reg) |-> (offset_reg < 4'(HDR_BYTES)))
        else $error("header window offset out of range");

endmodule

>>> design/jhds_header.sv
module jhds_header (
    input  jhds_pkg::hdr_win_t win,
    output jhds_pkg::hdr_res_t res
);
    import jhds_pkg::*;

    logic [15:0] seg_len;
    logic [16:0] adv;
    logic [4:0]  src;

    assign seg_len = {win[2], win[3]};
    assign adv = {1'b0, seg_len} + 17'd2;

    always_comb
    begin
        res = '0;
        src = '0;
        res.lost = (win[0] != MARK_PREFIX);
        res.found = !res.lost && (win[1] == MARK_SOF0 || win[1] == MARK_SOF2);
        res.scan = !res.lost && !res.found && (win[1] == MARK_SOS);
        res.height = {win[5], win[6]};
        res.width = {win[7], win[8]};
        if (adv >= 17'(HDR_BYTES))
        begin
            res.skip_count = adv - 17'(HDR_BYTES);
            res.to_skip = (res.skip_count != 17'd0);
            res.next_offset = 4'd0;
        end
        else
        begin
            res.next_offset = 4'(HDR_BYTES) - adv[3:0];
            for (int k = 0; k < HDR_BYTES; k++)
            begin
                src = 5'(k) + {1'b0, adv[3:0]};
                if (src < 5'(HDR_BYTES))
                begin
                    res.next_win[k] = win[src[3:0]];
                end
            end
        end
    end

endmodule

>>> tb/sv/jpeg_header_dimension_scan_core_test.sv
`timescale 1ns / 1ps

module jpeg_header_dimension_scan_core_test;

    import jhds_pkg::*;

    typedef enum logic [1:0] {
        WAIT_SOI0,
        WAIT_SOI1,
        FILL_HEADER,
        SKIP_PAYLOAD
    } scan_phase_e;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           byte_valid = 1'b0;
    logic           byte_ready;
    byte_item_t     byte_item = '0;
    logic           result_valid;
    logic           result_ready = 1'b0;
    result_item_t   result_item;

    scan_phase_e    scan_phase;
    logic [3:0]     held_count;
    logic [16:0]    skip_left;
    logic [15:0]    sof_height;
    logic [15:0]    sof_width;
    logic [2:0]     scan_outcome;
    logic [3:0]     seen_count;
    logic           scan_decided;
    logic [7:0]     header_bytes [0:HDR_BYTES-1];

    result_item_t   awaited_dimensions[$];
    logic [7:0]     file_bytes[$];
    int unsigned    mismatches = 0;
    int unsigned    bytes_accepted = 0;
    int unsigned    burst_left = 0;
    int unsigned    ready_cycle = 0;
    int unsigned    ready_mode = 0;

    jpeg_header_dimension_scan_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    always #5 clk = ~clk;

    task automatic clear_scan_state();
        scan_phase = WAIT_SOI0;
        held_count = '0;
        skip_left = '0;
        sof_height = '0;
        sof_width = '0;
        scan_outcome = ST_END;
        seen_count = '0;
        scan_decided = 1'b0;
        for (int k = 0; k < HDR_BYTES; k++)
        begin
            header_bytes[k] = '0;
        end
    endtask

    task automatic settle_scan(input logic [2:0] outcome);
        scan_decided = 1'b1;
        scan_outcome = outcome;
    endtask

    task automatic track_header_byte(input byte_item_t item);
        logic [16:0]  advance;
        result_item_t dims;
        if (seen_count < MIN_FILE)
        begin
            seen_count++;
        end
        if (!scan_decided)
        begin
            case (scan_phase)
                WAIT_SOI0:
                begin
                    if (item.data_byte != MARK_PREFIX)
                        settle_scan(ST_NOTJPEG);
                    else
                        scan_phase = WAIT_SOI1;
                end
                WAIT_SOI1:
                begin
                    if (item.data_byte != MARK_SOI)
                    begin
                        settle_scan(ST_NOTJPEG);
                    end
                    else
                    begin
                        scan_phase = FILL_HEADER;
                        held_count = '0;
                    end
                end
                FILL_HEADER:
                begin
                    if (held_count < HDR_BYTES)
                    begin
                        header_bytes[held_count] = item.data_byte;
                        held_count++;
                    end
                    if (held_count >= HDR_BYTES)
                    begin
                        if (header_bytes[0] != MARK_PREFIX)
                        begin
                            settle_scan(ST_LOST);
                        end
                        else if (header_bytes[1] == MARK_SOF0 || header_bytes[1] == MARK_SOF2)
                        begin
                            sof_height = {header_bytes[5], header_bytes[6]};
                            sof_width = {header_bytes[7], header_bytes[8]};
                            settle_scan(ST_FOUND);
                        end
                        else if (header_bytes[1] == MARK_SOS)
                        begin
                            settle_scan(ST_SCAN);
                        end
                        else
                        begin
                            advance = 17'd2 + {9'd0, header_bytes[2]} * 17'd256
                                + {9'd0, header_bytes[3]};
                            if (advance >= HDR_BYTES)
                            begin
                                skip_left = advance - 17'(HDR_BYTES);
                                held_count = '0;
                                scan_phase = (skip_left == 0) ? FILL_HEADER : SKIP_PAYLOAD;
                            end
                            else
                            begin
                                // A short segment starts the next header inside the held bytes.
                                for (int k = 0; k < HDR_BYTES - advance; k++)
                                begin
                                    header_bytes[k] = header_bytes[k + advance];
                                end
                                held_count = 4'(HDR_BYTES - advance);
                                scan_phase = FILL_HEADER;
                            end
                        end
                    end
                end
                default:
                begin
                    if (skip_left > 0)
                    begin
                        skip_left--;
                    end
                    if (skip_left == 0)
                    begin
                        scan_phase = FILL_HEADER;
                        held_count = '0;
                    end
                end
            endcase
        end
        if (item.final_byte)
        begin
            dims.scan_status = (seen_count < MIN_FILE) ? ST_SHORT : scan_outcome;
            dims.image_width = (dims.scan_status == ST_FOUND) ? sof_width : 16'd0;
            dims.image_height = (dims.scan_status == ST_FOUND) ? sof_height : 16'd0;
            awaited_dimensions.insert(awaited_dimensions.size(), dims);
            clear_scan_state();
        end
    endtask

    task automatic report_mismatch(input string text);
        $display("mismatch at %0t: %s", $time, text);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : check_results
        result_item_t want;
        if (result_valid && result_ready)
        begin
            if (awaited_dimensions.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result, status %0d",
                    result_item.scan_status));
            end
            else
            begin
                want = awaited_dimensions.pop_front();
                if (result_item.scan_status !== want.scan_status)
                    report_mismatch($sformatf("scan_status %0d, expected %0d",
                        result_item.scan_status, want.scan_status));
                if (result_item.image_width !== want.image_width)
                    report_mismatch($sformatf("image_width %0d, expected %0d",
                        result_item.image_width, want.image_width));
                if (result_item.image_height !== want.image_height)
                    report_mismatch($sformatf("image_height %0d, expected %0d",
                        result_item.image_height, want.image_height));
            end
        end
    end

    // The receiver switches at random between stall patterns.
    always @(posedge clk)
    begin : drive_result_ready
        ready_cycle++;
        if (ready_cycle % 200 == 0)
        begin
            ready_mode = $urandom_range(0, 3);
        end
        case (ready_mode)
            0: result_ready <= 1'b1;
            1: result_ready <= ($urandom_range(0, 1) == 1);
            2: result_ready <= (ready_cycle % 5 != 2);
            default: result_ready <= ((ready_cycle / 8) % 2 == 1);
        endcase
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        int unsigned gap;
        byte_valid <= 1'b1;
        byte_item <= '{data_byte: value, final_byte: last};
        @(posedge clk);
        while (!byte_ready)
        begin
            @(posedge clk);
        end
        track_header_byte(byte_item);
        bytes_accepted++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic append_byte(input logic [7:0] value);
        file_bytes.insert(file_bytes.size(), value);
    endtask

    task automatic send_file();
        for (int k = 0; k < file_bytes.size(); k++)
        begin
            send_byte(file_bytes[k], k == file_bytes.size() - 1);
        end
        file_bytes.delete();
    endtask

    task automatic trim_file(input int n);
        file_bytes = file_bytes[0:n-1];
    endtask

    task automatic add_soi();
        append_byte(MARK_PREFIX);
        append_byte(MARK_SOI);
    endtask

    task automatic add_segment(input logic [7:0] marker, input logic [15:0] len);
        append_byte(MARK_PREFIX);
        append_byte(marker);
        append_byte(len[15:8]);
        append_byte(len[7:0]);
        repeat ((len > 2) ? len - 2 : 0) append_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic add_sof(input logic [7:0] marker, input logic [15:0] height,
                           input logic [15:0] width);
        append_byte(MARK_PREFIX);
        append_byte(marker);
        append_byte(8'h00);
        append_byte(8'h11);
        append_byte(8'h08);
        append_byte(height[15:8]);
        append_byte(height[7:0]);
        append_byte(width[15:8]);
        append_byte(width[7:0]);
        repeat (3) append_byte(8'($urandom_range(0, 255)));
    endtask

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic test_too_short();
        file_bytes = {MARK_PREFIX};
        send_file();
        add_soi();
        add_sof(MARK_SOF0, 16'h1234, 16'h5678);
        trim_file(9);
        send_file();
        repeat (10) append_byte(8'h00);
        send_file();
        add_soi();
        add_sof(MARK_SOF0, 16'h0102, 16'h0304);
        trim_file(11);
        send_file();
    endtask

    task automatic test_not_jpeg();
        append_byte(8'h00);
        repeat (12) append_byte(MARK_PREFIX);
        send_file();
        append_byte(MARK_PREFIX);
        append_byte(8'hD9);
        repeat (12) append_byte(8'($urandom_range(0, 255)));
        send_file();
    endtask

    task automatic test_found();
        add_soi();
        add_segment(8'hE0, 16'd16);
        add_sof(MARK_SOF0, 16'hFFFF, 16'hFFFF);
        repeat (4) append_byte(8'hFF);
        send_file();
        add_soi();
        add_sof(MARK_SOF2, 16'h0000, 16'h0000);
        send_file();
    endtask

    task automatic test_scan_reached();
        add_soi();
        add_segment(8'hE1, 16'd8);
        add_segment(MARK_SOS, 16'd12);
        send_file();
    endtask

    task automatic test_lost_sync();
        add_soi();
        add_segment(8'hE0, 16'd12);
        append_byte(8'h00);
        repeat (8) append_byte(8'hFF);
        send_file();
        for (int len = 0; len < 2; len++)
        begin
            add_soi();
            add_segment(8'hE0, 16'(len));
            add_sof(MARK_SOF0, 16'h0040, 16'h0080);
            send_file();
        end
    endtask

    task automatic test_short_segments();
        for (int len = 2; len <= 6; len++)
        begin
            add_soi();
            add_segment(8'hFE, 16'(len));
            add_sof((len % 2 == 0) ? MARK_SOF0 : MARK_SOF2, pick_dim(), pick_dim());
            send_file();
        end
    endtask

    task automatic test_end_of_data();
        add_soi();
        add_segment(8'hE2, 16'd40);
        trim_file(26);
        send_file();
    endtask

    task automatic test_long_skip();
        add_soi();
        add_segment(8'hE1, 16'h0123);
        add_sof(MARK_SOF2, 16'h8001, 16'h7FFE);
        send_file();
    endtask

    task automatic test_random_files();
        int unsigned target;
        int          len;
        logic [7:0]  marker;
        target = 1850;
        while (bytes_accepted < target)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    repeat ($urandom_range(1, 16))
                        append_byte(8'($urandom_range(0, 255)));
                end
                1:
                begin
                    append_byte(MARK_PREFIX);
                    repeat ($urandom_range(9, 20))
                        append_byte(8'($urandom_range(0, 255)));
                end
                default:
                begin
                    add_soi();
                    repeat ($urandom_range(0, 3))
                    begin
                        marker = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                            : 8'($urandom_range(8'hE0, 8'hEF));
                        case ($urandom_range(0, 9))
                            0: len = $urandom_range(0, 1);
                            1: len = $urandom_range(25, 300);
                            default: len = $urandom_range(2, 24);
                        endcase
                        add_segment(marker, 16'(len));
                    end
                    case ($urandom_range(0, 5))
                        0: add_sof(MARK_SOF0, pick_dim(), pick_dim());
                        1: add_sof(MARK_SOF2, pick_dim(), pick_dim());
                        2: add_segment(MARK_SOS, 16'($urandom_range(6, 14)));
                        3:
                        begin
                            append_byte(8'($urandom_range(0, 254)));
                            repeat (8) append_byte(8'($urandom_range(0, 255)));
                        end
                        default:
                        begin
                            repeat (9) append_byte(8'($urandom_range(0, 255)));
                        end
                    endcase
                    repeat ($urandom_range(0, 6))
                        append_byte(8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 5) == 0)
                    begin
                        trim_file($urandom_range(1, file_bytes.size()));
                    end
                end
            endcase
            send_file();
        end
    endtask

    initial
    begin
        clear_scan_state();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_too_short();
        test_not_jpeg();
        test_found();
        test_scan_reached();
        test_lost_sync();
        test_short_segments();
        test_end_of_data();
        test_long_skip();
        test_random_files();
        byte_valid <= 1'b0;
        while (awaited_dimensions.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (mismatches == 0 && awaited_dimensions.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
